>>> sv/mcv_pkg.sv
// Package: shared types and constants of the multichannel valid-mode conv1d block.
package mcv_pkg;

  localparam int CNT_W   = 7;   // counts and indices up to 64
  localparam int SUM_W   = 40;
  localparam int POS_W   = 16;
  localparam int FILT_W  = 3;
  localparam int CHAN_W  = 2;
  localparam int TAP_W   = 3;
  localparam int REG_W   = 4;   // widest configuration register
  localparam int IDX_W   = 2;   // configuration register index

  localparam logic [IDX_W-1:0] REG_TAPS = 2'd0;
  localparam logic [IDX_W-1:0] REG_INS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUTS = 2'd2;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic             in_ready;
    logic             issue;     // one MAC read this cycle
    logic             first;     // first term of a sum
    logic             load_out;  // move accumulator to output register
    logic             last;
    logic [CNT_W-1:0] o;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] s;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start;     // accepted sample completes a full window
    logic out_free;  // output register can take a sum
  } status_t;

endpackage

>>> sv/mcv_if.sv
// Interfaces: input item channel and result item channel.
interface mcv_in_if #(parameter int SAMPLE_BITS = 16);
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [mcv_pkg::FILT_W-1:0]          filter_index;
  logic [mcv_pkg::CHAN_W-1:0]          channel_index;
  logic [mcv_pkg::TAP_W-1:0]           tap_index;
  logic signed [SAMPLE_BITS-1:0]       value;
  logic                                first_in_sequence;
  modport source (output valid, func, filter_index, channel_index, tap_index, value,
                  first_in_sequence, input ready);
  modport sink (input valid, func, filter_index, channel_index, tap_index, value,
                first_in_sequence, output ready);
endinterface

interface mcv_out_if;
  logic                              valid;
  logic                              ready;
  logic [mcv_pkg::FILT_W-1:0]        out_channel;
  logic [mcv_pkg::POS_W-1:0]         position;
  logic signed [mcv_pkg::SUM_W-1:0]  sum;
  logic                              last;
  modport source (output valid, out_channel, position, sum, last, input ready);
  modport sink (input valid, out_channel, position, sum, last, output ready);
endinterface

>>> sv/mcv_ctrl.sv
// Controller: sequences the MAC loop per output channel and the result handoff.
module mcv_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mcv_pkg::CNT_W-1:0]   taps,
  input  logic [mcv_pkg::CNT_W-1:0]   ins,
  input  logic [mcv_pkg::CNT_W-1:0]   outs,
  input  mcv_pkg::status_t            status,
  output mcv_pkg::cmd_t               cmd
);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                state, state_next;
  logic [mcv_pkg::CNT_W-1:0] o, o_next, k, k_next, s, s_next;
  logic [1:0]                drain, drain_next;
  logic                      s_end, k_end;

  assign s_end = (s == taps - 1'b1);
  assign k_end = (k == ins - 1'b1);

  always_comb begin
    state_next = state;
    o_next = o;
    k_next = k;
    s_next = s;
    drain_next = drain;
    cmd = '0;
    cmd.o = o;
    cmd.k = k;
    cmd.s = s;
    cmd.first = (k == '0) && (s == '0);
    cmd.last = (o == outs - 1'b1);
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        o_next = '0;
        k_next = '0;
        s_next = '0;
        if (status.start) state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (s_end) begin
          s_next = '0;
          if (k_end) begin
            k_next = '0;
            drain_next = '0;
            state_next = ST_DRAIN;
          end else begin
            k_next = k + 1'b1;
          end
        end else begin
          s_next = s + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_next = drain + 1'b1;
        if (drain == 2'd2) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          o_next = o + 1'b1;
          state_next = cmd.last ? ST_IDLE : ST_RUN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      o <= '0;
      k <= '0;
      s <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      o <= o_next;
      k <= k_next;
      s <= s_next;
      drain <= drain_next;
    end
  end

`ifndef SYNTHESIS
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !cmd.in_ready) else $error("input taken while busy");
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> (s < taps) && (k < ins) && (o < outs))
    else $error("MAC index out of range");
  a_emit_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && $past(state) != ST_EMIT |-> $past(state) == ST_DRAIN)
    else $error("emit without drain");
`endif
endmodule

>>> sv/mcv_dp.sv
// Datapath: window, kernel memory, MAC pipeline and output register.
module mcv_dp #(
  parameter int MAX_TAPS = 8,
  parameter int MAX_IN_CHANNELS = 4,
  parameter int MAX_OUT_CHANNELS = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mcv_pkg::CNT_W-1:0]   taps,
  input  logic [mcv_pkg::CNT_W-1:0]   ins,
  input  logic [mcv_pkg::CNT_W-1:0]   outs,
  input  mcv_pkg::cmd_t               cmd,
  output mcv_pkg::status_t            status,
  mcv_in_if.sink                      in_ch,
  mcv_out_if.source                   out_ch
);
  localparam int OB = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int CB = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int TB = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int AW = OB + CB + TB;
  localparam int PW = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] kmem [2**AW];
  logic signed [SAMPLE_BITS-1:0] win [MAX_TAPS][MAX_IN_CHANNELS];
  logic [mcv_pkg::CNT_W-1:0]     fill, fill_base, fill_inc;
  logic [mcv_pkg::POS_W-1:0]     pos, pos_base, pos_run;

  logic                          accept, is_sample, ch_ok, w_ok, col_done;
  logic [mcv_pkg::CNT_W-1:0]     c_in, col;
  logic signed [SAMPLE_BITS-1:0] kd, xd;
  logic signed [PW-1:0]          prod;
  logic [mcv_pkg::SUM_W-1:0]     acc;
  logic                          v1, f1, v2, f2;

  assign accept    = in_ch.valid && cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;
  assign is_sample = (in_ch.func == mcv_pkg::FUNC_SAMPLE);
  assign c_in      = mcv_pkg::CNT_W'(in_ch.channel_index);
  assign ch_ok     = c_in < ins;
  assign w_ok      = (mcv_pkg::CNT_W'(in_ch.filter_index) < outs) && ch_ok &&
                     (mcv_pkg::CNT_W'(in_ch.tap_index) < taps);
  assign fill_base = in_ch.first_in_sequence ? '0 : fill;
  assign pos_base  = in_ch.first_in_sequence ? '0 : pos;
  assign fill_inc  = (fill_base < taps) ? fill_base + 1'b1 : taps;
  assign col_done  = is_sample && ch_ok && (c_in == ins - 1'b1);
  assign status.start = accept && col_done && (fill_inc >= taps);
  assign status.out_free = !out_ch.valid || out_ch.ready;
  assign col = taps - 1'b1 - cmd.s;

  // kernel memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && !is_sample && w_ok)
      kmem[{OB'(in_ch.filter_index), CB'(in_ch.channel_index), TB'(in_ch.tap_index)}]
        <= in_ch.value;
    kd <= kmem[{cmd.o[OB-1:0], cmd.k[CB-1:0], cmd.s[TB-1:0]}];
    xd <= win[col[TB-1:0]][cmd.k[CB-1:0]];
  end

  // window, fill and position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_TAPS; t++)
        for (int c = 0; c < MAX_IN_CHANNELS; c++)
          win[t][c] <= '0;
      fill <= '0;
      pos <= '0;
    end else if (accept && is_sample && ch_ok) begin
      if (c_in == '0) begin
        for (int t = 1; t < MAX_TAPS; t++)
          for (int c = 0; c < MAX_IN_CHANNELS; c++)
            win[t][c] <= win[t-1][c];
      end
      win[0][CB'(in_ch.channel_index)] <= in_ch.value;
      fill <= col_done ? fill_inc : fill_base;
      if (status.start) begin
        pos_run <= pos_base;
        pos <= pos_base + 1'b1;
      end else begin
        pos <= pos_base;
      end
    end
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
    f1 <= cmd.first;
    f2 <= f1;
    prod <= kd * xd;
    if (v2) acc <= f2 ? mcv_pkg::SUM_W'(prod) : acc + mcv_pkg::SUM_W'(prod);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (cmd.load_out) begin
      out_ch.out_channel <= mcv_pkg::FILT_W'(cmd.o);
      out_ch.position <= pos_run;
      out_ch.sum <= acc;
      out_ch.last <= cmd.last;
    end
  end
endmodule

>>> sv/multichannel_conv1d_valid_core.sv
// Top level: multichannel valid-mode 1D convolution (cross-correlation), Q1.15.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | func, filter_index, channel_index, tap_index, value,
//           |     |               | first_in_sequence
//  out_ch   | out | valid/ready   | out_channel, position, sum, last
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// A weight or a sample that does not complete a full window is taken in the idle state.
// A completed column runs, per output channel, taps*ins products through the
// single shared MAC, then a pipeline drain and the handoff to the output
// register; the one MAC and the kernel memory port set the pace. Input is held
// off while sums are computed; a finished sum waits in the output register
// without blocking the next input item. Reset (synchronous) clears the window,
// fill, position and output valid, presets the configuration, keeps kernel memory.
module multichannel_conv1d_valid_core #(
  parameter int MAX_TAPS = 8,
  parameter int MAX_IN_CHANNELS = 4,
  parameter int MAX_OUT_CHANNELS = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  mcv_in_if.sink                      in_ch,
  mcv_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [mcv_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mcv_pkg::REG_W-1:0]   cfg_data
);
  logic [3:0]                taps_reg;
  logic [2:0]                ins_reg;
  logic [3:0]                outs_reg;
  logic [mcv_pkg::CNT_W-1:0] taps, ins, outs;
  mcv_pkg::cmd_t             cmd;
  mcv_pkg::status_t          status;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_reg <= 4'd8;
      ins_reg  <= 3'd4;
      outs_reg <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        mcv_pkg::REG_TAPS: taps_reg <= cfg_data;
        mcv_pkg::REG_INS:  ins_reg  <= cfg_data[2:0];
        mcv_pkg::REG_OUTS: outs_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp each register to 1..its maximum; zero counts as one
  always_comb begin
    taps = mcv_pkg::CNT_W'(taps_reg);
    if (taps == '0) taps = mcv_pkg::CNT_W'(1);
    else if (taps > mcv_pkg::CNT_W'(MAX_TAPS)) taps = mcv_pkg::CNT_W'(MAX_TAPS);
    ins = mcv_pkg::CNT_W'(ins_reg);
    if (ins == '0) ins = mcv_pkg::CNT_W'(1);
    else if (ins > mcv_pkg::CNT_W'(MAX_IN_CHANNELS)) ins = mcv_pkg::CNT_W'(MAX_IN_CHANNELS);
    outs = mcv_pkg::CNT_W'(outs_reg);
    if (outs == '0) outs = mcv_pkg::CNT_W'(1);
    else if (outs > mcv_pkg::CNT_W'(MAX_OUT_CHANNELS))
      outs = mcv_pkg::CNT_W'(MAX_OUT_CHANNELS);
  end

  mcv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .taps(taps), .ins(ins), .outs(outs),
    .status(status), .cmd(cmd)
  );

  mcv_dp #(
    .MAX_TAPS(MAX_TAPS), .MAX_IN_CHANNELS(MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .taps(taps), .ins(ins), .outs(outs),
    .cmd(cmd), .status(status), .in_ch(in_ch), .out_ch(out_ch)
  );

`ifndef SYNTHESIS
  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last |->
      mcv_pkg::CNT_W'(out_ch.out_channel) == outs - 1'b1)
    else $error("last on wrong channel");
  a_not_last_below: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.last |->
      mcv_pkg::CNT_W'(out_ch.out_channel) < outs - 1'b1)
    else $error("missing last");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free) else $error("output overwritten");
`endif
endmodule
